// ===== hw/rtl/key_state_change_events_assert.svh =====
// Assertion macros used by the checker of the key state change block.
`ifndef KEY_STATE_CHANGE_EVENTS_ASSERT_SVH
`define KEY_STATE_CHANGE_EVENTS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSCE_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error("key state change check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSCE_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error("key state change check failed");

// Next-cycle implication that is also checked across reset.
`define KSCE_ASSERT_ALWAYS(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) (ant) |=> (con)) \
        else $error("key state change check failed");

`endif

// ===== hw/rtl/kse_pkg.sv =====
// Package with the constants and types of the key state change block.
package kse_pkg;

    localparam int PACKET_BYTES = 8;
    localparam int KEY_COUNT    = 64;
    localparam int PKT_BITS     = PACKET_BYTES * 8;
    localparam int POS_W        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = IDX_W + 1;

    typedef struct packed {
        logic                load;
        logic [PKT_BITS-1:0] bits;
    } kse_word_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SCAN,
        SC_FLUSH
    } kse_scan_state_t;

endpackage

// ===== hw/rtl/kse_deser.sv =====
// Byte deserializer that shifts received bytes into one key-state word.
module kse_deser import kse_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            enable,
    input  logic            byte_accept,
    input  logic [7:0]      rx_byte,
    output kse_word_t       word
);

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [PKT_BITS-1:0] asm_reg;
    logic [PKT_BITS-1:0] asm_next;
    logic [PKT_BITS-1:0] asm_shift;
    logic                last_byte;

    generate
        if (PKT_BITS == 8) begin : g_single
            assign asm_shift = rx_byte;
        end else begin : g_multi
            assign asm_shift = {rx_byte, asm_reg[PKT_BITS-1:8]};
        end
    endgenerate

    assign last_byte = (pos_reg == POS_W'(PACKET_BYTES - 1));

    always_comb begin
        pos_next = pos_reg;
        asm_next = asm_reg;
        if (byte_accept) begin
            if (!enable) begin
                pos_next = '0;
            end else begin
                asm_next = asm_shift;
                pos_next = last_byte ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
    end

    assign word.load = byte_accept && enable && last_byte;
    assign word.bits = asm_shift;

endmodule

// ===== hw/rtl/kse_scan.sv =====
// Bit-serial compare of a new key-state word against the stored word, with event output.
module kse_scan import kse_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  kse_word_t        word,
    output logic             busy,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [IDX_W-1:0] key_index,
    output logic             key_level,
    output logic             last_event
);

    kse_scan_state_t     state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PKT_BITS-1:0] new_reg, new_next;
    logic [KEY_COUNT-1:0] prev_reg, prev_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_index_reg, pend_index_next;
    logic                pend_level_reg, pend_level_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic                out_level_reg, out_level_next;
    logic                out_last_reg, out_last_next;
    logic                new_bit;
    logic                diff_bit;
    logic                out_free;

    assign new_bit  = ({1'b0, idx_reg} < CNT_W'(PKT_BITS)) ? new_reg[0] : 1'b0;
    assign diff_bit = new_bit ^ prev_reg[0];
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        new_next        = new_reg;
        prev_next       = prev_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        pend_level_next = pend_level_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_level_next  = out_level_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            SC_IDLE: begin
                if (word.load) begin
                    new_next   = word.bits;
                    idx_next   = '0;
                    state_next = SC_SCAN;
                end
            end
            SC_SCAN: begin
                if (!(diff_bit && pend_valid_reg && !out_free)) begin
                    prev_next = {new_bit, prev_reg[KEY_COUNT-1:1]};
                    new_next  = new_reg >> 1;
                    idx_next  = idx_reg + IDX_W'(1);
                    if (diff_bit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_index_next = pend_index_reg;
                            out_level_next = pend_level_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = idx_reg;
                        pend_level_next = new_bit;
                    end
                    if (idx_reg == IDX_W'(KEY_COUNT - 1)) begin
                        state_next = SC_FLUSH;
                    end
                end
            end
            SC_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = SC_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_index_reg;
                    out_level_next  = pend_level_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SC_IDLE;
                end
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SC_IDLE;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        pend_index_reg <= pend_index_next;
        pend_level_reg <= pend_level_next;
        out_index_reg  <= out_index_next;
        out_level_reg  <= out_level_next;
        out_last_reg   <= out_last_next;
    end

    assign busy       = (state_reg != SC_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign key_index  = out_index_reg;
    assign key_level  = out_level_reg;
    assign last_event = out_last_reg;

endmodule

// ===== hw/rtl/key_state_change_events.sv =====
// Top level of the key state change event block.
// Each accepted item is one received byte; eight bytes, first byte lowest, form a 64-bit
// key-state word. A byte that does not complete a word is taken without a stall. The byte that
// completes a word starts a bit-serial scan that walks the 64 keys one per cycle against the
// stored word, pausing while m_tready holds back a pending event, and then releases the final
// event; s_tready stays low through the scan and the release. One item leaves per
// changed key in ascending key order, with m_tlast on the last one. While enable is 0 bytes
// are taken and dropped and the next byte starts a new word.
module key_state_change_events import kse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] key_index, [6] key_level, [7] zero
    output logic       m_tlast    // last_event
);

    logic             enable_reg;
    logic             busy;
    logic             byte_accept;
    kse_word_t        word;
    logic [IDX_W-1:0] key_index;
    logic             key_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
        end
    end

    assign s_tready    = !busy;
    assign byte_accept = s_tvalid && s_tready;

    kse_deser u_deser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .enable      (enable_reg),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .word        (word)
    );

    kse_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word       (word),
        .busy       (busy),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .key_index  (key_index),
        .key_level  (key_level),
        .last_event (m_tlast)
    );

    assign m_tdata = {1'b0, key_level, key_index};

endmodule

// ===== hw/rtl/kse_checker.sv =====
// Port-level checker for the key state change block, bound to the top level.
`include "key_state_change_events_assert.svh"

module kse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       mid_reg;
    logic [5:0] last_idx_reg;
    logic       out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= 1'b0;
        end else if (out_acc) begin
            mid_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            last_idx_reg <= m_tdata[5:0];
        end
    end

    // Events of one word come out in strictly ascending key order.
    `KSCE_ASSERT_NOW(a_ascending, out_acc && mid_reg, m_tdata[5:0] > last_idx_reg)
    // The padding bit of the result data is always zero.
    `KSCE_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7] == 1'b0)
    // A stalled result stays offered.
    `KSCE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    // Reset leaves the block empty and ready for a byte.
    `KSCE_ASSERT_ALWAYS(a_reset, !aresetn, !m_tvalid && s_tready)

endmodule

bind key_state_change_events kse_checker u_kse_checker (.*);

// ===== dv/tb_key_state_change_events.sv =====
`timescale 1ns / 100ps
// Testbench for the key state change block: random and directed key packets against a predictor.
module tb_key_state_change_events;
    import kse_pkg::PACKET_BYTES;
    import kse_pkg::KEY_COUNT;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TIME  = 2 * KEY_COUNT;
    localparam int RANDOM_BYTES = 300;
    localparam int PRINT_LIMIT  = 20;

    typedef struct packed {
        logic [5:0] index;
        logic       level;
        logic       last;
    } key_event_t;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    logic [7:0]  rx_bytes[$];
    key_event_t  key_events[$];

    logic        key_enable   = 1'b0;
    int          byte_pos     = 0;
    logic [63:0] partial_keys = '0;
    logic [63:0] prev_keys    = '0;

    bit          idle_on      = 1'b1;
    int          s_gap        = 0;
    int          stall_left   = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;

    key_state_change_events dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void predict_key_events(input logic [7:0] rx);
        logic [63:0] word;
        logic [63:0] diff;
        int          pos;
        key_event_t  ev;
        if (!key_enable) begin
            byte_pos = 0;
            return;
        end
        pos = (byte_pos >= PACKET_BYTES) ? 0 : byte_pos;
        if (pos == 0) begin
            partial_keys = '0;
        end
        word = partial_keys | (64'(rx) << (8 * pos));
        if (pos + 1 < PACKET_BYTES) begin
            partial_keys = word;
            byte_pos = pos + 1;
            return;
        end
        byte_pos = 0;
        diff = word ^ prev_keys;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (diff[i]) begin
                ev.index = i[5:0];
                ev.level = word[i];
                ev.last  = ((diff >> i) >> 1) == 64'd0;
                key_events.push_back(ev);
            end
        end
        prev_keys = word;
    endfunction

    task automatic queue_word(input logic [63:0] word);
        for (int k = 0; k < PACKET_BYTES; k++) begin
            rx_bytes.push_back(word[8*k +: 8]);
        end
    endtask

    task automatic queue_random_bytes(input int count);
        repeat (count) rx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic write_enable(input bit value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        key_enable   = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // A packet without changes keeps the block scanning with no event to show for it.
    task automatic wait_idle();
        @(negedge aclk);
        while (rx_bytes.size() != 0 || s_tvalid || key_events.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_TIME) @(negedge aclk);
    endtask

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_gap != 0) begin
                s_tvalid <= 1'b0;
                s_gap    <= s_gap - 1;
            end else if (rx_bytes.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes.pop_front();
                s_gap    <= idle_on ? $urandom_range(0, 3) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        key_event_t want;
        int         stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_key_events(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (key_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event key %0d level %0b last %0b",
                        m_tdata[5:0], m_tdata[6], m_tlast));
                end else begin
                    want = key_events.pop_front();
                    if (m_tdata[5:0] !== want.index || m_tdata[6] !== want.level
                            || m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "event key %0d level %0b last %0b, expected key %0d level %0b last %0b",
                            m_tdata[5:0], m_tdata[6], m_tlast,
                            want.index, want.level, want.last));
                    end
                end
                stall = idle_on ? $urandom_range(0, 3) : 0;
                m_tready   <= (stall == 0);
                stall_left <= (stall == 0) ? 0 : stall - 1;
            end else if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] word;
        logic [63:0] last_word;
        bit          phase_en;
        int          sent;
        int          mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Bytes are dropped while disabled after reset.
        @(negedge aclk);
        queue_random_bytes(2);
        wait_idle();

        // An all-zero word matches the cleared state, then all keys change to level 1 at once.
        write_enable(1'b1);
        @(negedge aclk);
        queue_word(64'd0);
        queue_word({64{1'b1}});
        queue_random_bytes(3);
        wait_idle();

        // Disabling in the middle of a packet restarts the framing.
        write_enable(1'b0);
        @(negedge aclk);
        queue_random_bytes(1);
        wait_idle();

        last_word = {64{1'b1}};
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            phase_en = ($urandom_range(0, 4) != 0);
            write_enable(phase_en);
            idle_on = ($urandom_range(0, 3) != 0);
            @(negedge aclk);
            if (!phase_en) begin
                queue_random_bytes($urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(2, 6)) begin
                    mode = $urandom_range(0, 9);
                    if (mode <= 2) begin
                        word = {$urandom, $urandom};
                    end else if (mode <= 6) begin
                        word = last_word;
                        repeat ($urandom_range(1, 3)) begin
                            mode = $urandom_range(0, 63);
                            word[mode] = ~word[mode];
                        end
                    end else if (mode == 7) begin
                        word = last_word;
                    end else if (mode == 8) begin
                        word = 64'd0;
                    end else begin
                        word = {64{1'b1}};
                    end
                    queue_word(word);
                    last_word = word;
                    sent += PACKET_BYTES;
                end
                if (PACKET_BYTES > 1 && $urandom_range(0, 3) == 0) begin
                    mode = $urandom_range(1, PACKET_BYTES - 1);
                    queue_random_bytes(mode);
                    sent += mode;
                end
            end
            wait_idle();
        end

        repeat (SETTLE_TIME) @(negedge aclk);
        if (key_events.size() != 0) begin
            report_mismatch($sformatf("%0d expected events never arrived", key_events.size()));
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
